// ===== rtl/core/udcd_pkg.sv =====
// shared types and constants for the uart dimmer command decoder
// line length, character codes, command codes and inter-module structs
// no dependencies

package udcd_pkg;

  localparam int LINE_LEN  = 4;
  localparam int STORE_LEN = LINE_LEN + 1;
  localparam int CNT_W     = $clog2(STORE_LEN + 1);
  localparam int IDX_W     = $clog2(STORE_LEN);
  localparam int CHAR_W    = 8;
  localparam int LEVEL_W   = 7;
  localparam int CMD_W     = 3;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [LEVEL_W-1:0] level_t;

  localparam char_t CH_NUL  = 8'd0;
  localparam char_t CH_BS   = 8'd8;
  localparam char_t CH_LF   = 8'd10;
  localparam char_t CH_CR   = 8'd13;
  localparam char_t CH_SP   = 8'd32;
  localparam char_t CH_DEL  = 8'd127;
  localparam char_t CH_ZERO = 8'h30;
  localparam char_t CH_NINE = 8'h39;
  localparam char_t CH_B    = 8'h62;
  localparam char_t CH_G    = 8'h67;
  localparam char_t CH_I    = 8'h69;
  localparam char_t CH_N    = 8'h6e;
  localparam char_t CH_F    = 8'h66;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE  = 3'd0,
    CMD_BLUE  = 3'd1,
    CMD_GREEN = 3'd2,
    CMD_BOTH  = 3'd3,
    CMD_INFO  = 3'd4,
    CMD_BAD   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    CLS_STORE,
    CLS_END,
    CLS_ERASE,
    CLS_RECALL
  } char_cls_t;

  // step request from the top level to the line buffer
  typedef struct packed {
    logic      step;
    char_cls_t cls;
    char_t     ch;
  } line_ctl_t;

  // decoded line
  typedef struct packed {
    cmd_t   cmd;
    level_t level;
    logic   set_blue;
    logic   set_green;
  } dec_res_t;

endpackage

// ===== rtl/core/udcd_if.sv =====
// handshake channels of the uart dimmer command decoder
// valid/ready with the character in and the decoded result out
// depends on udcd_pkg

interface udcd_in_if;
  logic                 valid;
  logic                 ready;
  udcd_pkg::char_t      rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink   (input valid, input rx_char, output ready);
endinterface

interface udcd_out_if;
  logic                 valid;
  logic                 ready;
  udcd_pkg::char_t      echo_char;
  logic [udcd_pkg::CMD_W-1:0] command;
  udcd_pkg::level_t     level_value;
  udcd_pkg::level_t     blue_level;
  udcd_pkg::level_t     green_level;
  logic                 recalled;

  modport source (output valid, output echo_char, output command, output level_value,
                  output blue_level, output green_level, output recalled, input ready);
  modport sink   (input valid, input echo_char, input command, input level_value,
                  input blue_level, input green_level, input recalled, output ready);
endinterface

// ===== rtl/core/udcd_line_buf.sv =====
// line store, last completed line and character count
// handles store, erase, recall and line end steps
// depends on udcd_pkg

module udcd_line_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  udcd_pkg::line_ctl_t ctl,
  output udcd_pkg::char_t     line_o [udcd_pkg::LINE_LEN],
  output udcd_pkg::cnt_t      count_o
);

  udcd_pkg::char_t store_r  [udcd_pkg::STORE_LEN];
  udcd_pkg::char_t store_nxt[udcd_pkg::STORE_LEN];
  udcd_pkg::char_t last_r   [udcd_pkg::LINE_LEN];
  udcd_pkg::char_t last_nxt [udcd_pkg::LINE_LEN];
  udcd_pkg::cnt_t  cnt_r;
  udcd_pkg::cnt_t  cnt_nxt;
  udcd_pkg::cnt_t  rec_cnt;
  udcd_pkg::idx_t  wr_idx;
  logic            has_room;

  assign wr_idx   = cnt_r[udcd_pkg::IDX_W-1:0];
  assign has_room = (cnt_r < udcd_pkg::cnt_t'(udcd_pkg::STORE_LEN));

  // recall length: first terminator in the last line
  always_comb begin
    rec_cnt = udcd_pkg::cnt_t'(udcd_pkg::LINE_LEN);
    for (int i = udcd_pkg::LINE_LEN - 1; i >= 0; i--) begin
      if (last_r[i] == udcd_pkg::CH_NUL) begin
        rec_cnt = udcd_pkg::cnt_t'(i);
      end
    end
  end

  always_comb begin
    udcd_pkg::char_t term [udcd_pkg::STORE_LEN];
    store_nxt = store_r;
    last_nxt  = last_r;
    cnt_nxt   = cnt_r;
    term      = store_r;
    if (ctl.step) begin
      case (ctl.cls)
        udcd_pkg::CLS_END: begin
          if (has_room) begin
            term[wr_idx] = udcd_pkg::CH_NUL;
          end
          for (int i = 0; i < udcd_pkg::LINE_LEN; i++) begin
            last_nxt[i] = term[i];
          end
          for (int i = 0; i < udcd_pkg::STORE_LEN; i++) begin
            store_nxt[i] = udcd_pkg::CH_SP;
          end
          cnt_nxt = '0;
        end
        udcd_pkg::CLS_ERASE: begin
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        udcd_pkg::CLS_RECALL: begin
          for (int i = 0; i < udcd_pkg::LINE_LEN; i++) begin
            store_nxt[i] = last_r[i];
          end
          cnt_nxt = rec_cnt;
        end
        udcd_pkg::CLS_STORE: begin
          if (has_room) begin
            store_nxt[wr_idx] = ctl.ch;
            cnt_nxt           = cnt_r + 1'b1;
          end else begin
            cnt_nxt = '0;
          end
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int i = 0; i < udcd_pkg::STORE_LEN; i++) begin
        store_r[i] <= udcd_pkg::CH_NUL;
      end
      for (int i = 0; i < udcd_pkg::LINE_LEN; i++) begin
        last_r[i] <= udcd_pkg::CH_NUL;
      end
    end else begin
      cnt_r   <= cnt_nxt;
      store_r <= store_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < udcd_pkg::LINE_LEN; i++) begin
      line_o[i] = store_r[i];
    end
  end

  assign count_o = cnt_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= udcd_pkg::cnt_t'(udcd_pkg::STORE_LEN))
    else $error("line count beyond store length");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step && (ctl.cls == udcd_pkg::CLS_END) |=> cnt_r == '0)
    else $error("line end did not clear count");
`endif

endmodule

// ===== rtl/core/udcd_decode.sv =====
// line decoder: bNN, gNN, gbNN/bgNN, inf or invalid
// purely combinational, reads the head of the line store
// depends on udcd_pkg

module udcd_decode (
  input  udcd_pkg::char_t    line_i [udcd_pkg::LINE_LEN],
  input  udcd_pkg::cnt_t     count_i,
  output udcd_pkg::dec_res_t res_o
);

  function automatic logic is_digit(udcd_pkg::char_t c);
    return (c >= udcd_pkg::CH_ZERO) && (c <= udcd_pkg::CH_NINE);
  endfunction

  // tens*10 + units, digits already checked
  function automatic udcd_pkg::level_t two_digits(udcd_pkg::char_t t, udcd_pkg::char_t u);
    logic [3:0] td;
    logic [3:0] ud;
    td = t[3:0];
    ud = u[3:0];
    return udcd_pkg::level_t'({td, 3'b000}) + udcd_pkg::level_t'({td, 1'b0})
         + udcd_pkg::level_t'(ud);
  endfunction

  logic            len3;
  logic            len4;
  logic            dig12;
  logic            dig23;
  logic            pair;
  udcd_pkg::level_t lvl3;
  udcd_pkg::level_t lvl4;

  assign len3  = (count_i == udcd_pkg::cnt_t'(3));
  assign len4  = (count_i == udcd_pkg::cnt_t'(4));
  assign dig12 = is_digit(line_i[1]) && is_digit(line_i[2]);
  assign dig23 = is_digit(line_i[2]) && is_digit(line_i[3]);
  assign pair  = ((line_i[0] == udcd_pkg::CH_G) && (line_i[1] == udcd_pkg::CH_B))
              || ((line_i[0] == udcd_pkg::CH_B) && (line_i[1] == udcd_pkg::CH_G));
  assign lvl3  = two_digits(line_i[1], line_i[2]);
  assign lvl4  = two_digits(line_i[2], line_i[3]);

  always_comb begin
    res_o = '{cmd: udcd_pkg::CMD_BAD, level: '0, set_blue: 1'b0, set_green: 1'b0};
    if (len3 && dig12) begin
      if (line_i[0] == udcd_pkg::CH_B) begin
        res_o = '{cmd: udcd_pkg::CMD_BLUE, level: lvl3, set_blue: 1'b1, set_green: 1'b0};
      end else if (line_i[0] == udcd_pkg::CH_G) begin
        res_o = '{cmd: udcd_pkg::CMD_GREEN, level: lvl3, set_blue: 1'b0, set_green: 1'b1};
      end
    end else if (len4 && pair && dig23) begin
      res_o = '{cmd: udcd_pkg::CMD_BOTH, level: lvl4, set_blue: 1'b1, set_green: 1'b1};
    end else if (len3 && (line_i[0] == udcd_pkg::CH_I) && (line_i[1] == udcd_pkg::CH_N)
                 && (line_i[2] == udcd_pkg::CH_F)) begin
      res_o.cmd = udcd_pkg::CMD_INFO;
    end
  end

endmodule

// ===== rtl/core/uart_dimmer_command_decoder.sv =====
// top level of the uart dimmer command decoder
// input register, line buffer, line decoder, level registers, result register
// depends on udcd_pkg, udcd_if, udcd_line_buf, udcd_decode
//
//   channel | direction | payload
//   --------+-----------+---------------------------------------------------------
//   in_ch   | sink      | rx_char
//   out_ch  | source    | echo_char, command, level_value, blue_level, green_level,
//           |           | recalled
//
// one result per character; a character goes through the input register, then the
// result register; one character is taken every cycle while out_ch is not stalled
// the line store update and decode sit between the two registers in a single pass
// reset (rst_n low, synchronous) empties both stages, clears the line store,
// the last line, the count and both levels
// a stalled result register holds its result; the input register keeps taking
// characters until both stages are full

module uart_dimmer_command_decoder (
  input logic         clk,
  input logic         rst_n,
  udcd_in_if.sink     in_ch,
  udcd_out_if.source  out_ch
);

  // input stage
  logic               in_valid_r;
  udcd_pkg::char_t    in_char_r;
  logic               adv;

  // level registers
  udcd_pkg::level_t   blue_r;
  udcd_pkg::level_t   blue_nxt;
  udcd_pkg::level_t   green_r;
  udcd_pkg::level_t   green_nxt;

  // result stage
  logic               out_valid_r;
  udcd_pkg::char_t    out_echo_r;
  udcd_pkg::cmd_t     out_cmd_r;
  udcd_pkg::level_t   out_level_r;
  udcd_pkg::level_t   out_blue_r;
  udcd_pkg::level_t   out_green_r;
  logic               out_rec_r;

  udcd_pkg::char_cls_t cls;
  udcd_pkg::line_ctl_t ctl;
  udcd_pkg::char_t     line [udcd_pkg::LINE_LEN];
  udcd_pkg::cnt_t      count;
  udcd_pkg::dec_res_t  dec;
  logic                is_end;

  // the input stage moves on when the result register is free or being drained
  assign adv         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_char_r <= in_ch.rx_char;
    end
  end

  // character classes: line end, erase, recall, anything else is stored
  always_comb begin
    unique case (in_char_r) inside
      udcd_pkg::CH_CR, udcd_pkg::CH_LF:  cls = udcd_pkg::CLS_END;
      udcd_pkg::CH_BS, udcd_pkg::CH_DEL: cls = udcd_pkg::CLS_ERASE;
      udcd_pkg::CH_SP:                   cls = udcd_pkg::CLS_RECALL;
      default:                           cls = udcd_pkg::CLS_STORE;
    endcase
  end

  assign is_end = (cls == udcd_pkg::CLS_END);
  assign ctl    = '{step: adv, cls: cls, ch: in_char_r};

  udcd_line_buf u_line_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .line_o  (line),
    .count_o (count)
  );

  // decode sees the line before this step; the terminator never lands inside it
  udcd_decode u_decode (
    .line_i  (line),
    .count_i (count),
    .res_o   (dec)
  );

  assign blue_nxt  = (adv && is_end && dec.set_blue)  ? dec.level : blue_r;
  assign green_nxt = (adv && is_end && dec.set_green) ? dec.level : green_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blue_r  <= '0;
      green_r <= '0;
    end else begin
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_echo_r  <= in_char_r;
      out_cmd_r   <= is_end ? dec.cmd : udcd_pkg::CMD_NONE;
      out_level_r <= is_end ? dec.level : '0;
      out_blue_r  <= blue_nxt;
      out_green_r <= green_nxt;
      out_rec_r   <= (cls == udcd_pkg::CLS_RECALL);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.echo_char   = out_echo_r;
  assign out_ch.command     = out_cmd_r;
  assign out_ch.level_value = out_level_r;
  assign out_ch.blue_level  = out_blue_r;
  assign out_ch.green_level = out_green_r;
  assign out_ch.recalled    = out_rec_r;

`ifndef SYNTHESIS
  a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(blue_r) && $stable(green_r))
    else $error("level changed without a transfer");

  a_end_gives_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    adv && is_end |=> out_cmd_r != udcd_pkg::CMD_NONE)
    else $error("line end produced no command");

  a_recall_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rec_r |-> out_cmd_r == udcd_pkg::CMD_NONE)
    else $error("recall carries a command");

  a_result_levels: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_blue_r == blue_r) && (out_green_r == green_r))
    else $error("result levels differ from level registers");
`endif

endmodule
